/* rtl/rflr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rflr_pkg
// Shared types and constants of the replica file list reconciler.
// ----------------------------------------------------------------------------
package rflr_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = 6;    // index into the peer table
  localparam int unsigned CNT_W = 7;    // holds 0..DEPTH

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] CAT_MORE = 2'd0;
  localparam logic [1:0] CAT_DIFF = 2'd1;
  localparam logic [1:0] CAT_LESS = 2'd2;
  localparam logic [1:0] CAT_NONE = 2'd3;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] id;
    logic [31:0] size;
    logic [31:0] crc;
    logic [7:0]  status;
  } item_t;

  typedef struct packed {
    logic [1:0]  category;
    logic [63:0] id;
    logic        last;
    logic        overflow;
    logic [15:0] more_total;
    logic [15:0] diff_total;
    logic [15:0] less_total;
  } res_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] size;
    logic [31:0] crc;
    logic [7:0]  status;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* rtl/rflr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rflr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rflr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/rflr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rflr_front
// Input side: accepts transactions, drops unknown commands, and holds up to
// two commands for the back end.
// ----------------------------------------------------------------------------
module rflr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire rflr_pkg::item_t item_i,
  output logic                out_valid_o,
  output rflr_pkg::item_t     out_item_o,
  input  wire logic           pop_i
);

  rflr_pkg::item_t buf_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_q, rd_q;
  logic       store, take;

  assign full_o      = (count_q == 2'd2);
  assign store       = push_i && !full_o && (item_i.cmd != rflr_pkg::CMD_NOP);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = buf_q[rd_q];
  assign take        = pop_i && out_valid_o;

  always_comb begin
    count_d = count_q;
    if (store && !take) begin
      count_d = count_q + 2'd1;
    end else if (take && !store) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (store) wr_q <= !wr_q;
      if (take)  rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/rflr_outq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rflr_outq
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module rflr_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rflr_pkg::res_t res_i,
  output logic               full_o,
  output logic               empty_o,
  output rflr_pkg::res_t     res_o,
  input  wire logic          pop_i
);

  rflr_pkg::res_t buf_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_q, rd_q;
  logic       store, take;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign store   = push_i && !full_o;
  assign take    = pop_i && !empty_o;
  assign res_o   = buf_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (store && !take) begin
      count_d = count_q + 2'd1;
    end else if (take && !store) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (store) wr_q <= !wr_q;
      if (take)  rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      buf_q[wr_q] <= res_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/rflr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rflr_back
// Execution engine: peer table in RAM, swept one entry per cycle for key
// lookup, pending-entry marking and the minimum-key search of a drain.
// ----------------------------------------------------------------------------
module rflr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     mask_i,
  input  wire logic           in_valid_i,
  input  wire rflr_pkg::item_t in_item_i,
  output logic                in_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output rflr_pkg::res_t      res_o
);

  localparam int unsigned IW = rflr_pkg::IDX_W;
  localparam int unsigned CW = rflr_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(rflr_pkg::DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_PEND   = 3'd4;
  localparam logic [2:0] S_MIN    = 3'd5;

  logic [2:0] state_q, state_d;
  rflr_pkg::item_t cur_q, cur_d;
  logic [rflr_pkg::DEPTH-1:0] valid_q, valid_d, pend_q, pend_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          chk_q, chk_d;
  logic [IW-1:0] eidx_q, eidx_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  rflr_pkg::entry_t hit_ent_q, hit_ent_d;
  logic [CW-1:0] npend_q, npend_d, remain_q, remain_d;
  logic          best_q, best_d;
  logic [63:0]   best_key_q, best_key_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [15:0]   more_q, more_d, diff_q, diff_d, less_q, less_d;
  logic          ovf_q, ovf_d;
  rflr_pkg::res_t res_q, res_d;

  logic          we;
  logic [IW-1:0] waddr;
  logic [rflr_pkg::ENTRY_W-1:0] rdata;
  rflr_pkg::entry_t rent;
  logic          sweep_done;
  logic          free_any;
  logic [IW-1:0] free_idx;
  logic [16:0]   less_sum;
  logic [15:0]   less_sat;

  rflr_ram #(
    .WIDTH(rflr_pkg::ENTRY_W),
    .DEPTH(rflr_pkg::DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({cur_q.id, cur_q.size, cur_q.crc, cur_q.status}),
    .raddr_i(idx_q[IW-1:0]),
    .rdata_o(rdata)
  );

  assign rent       = rflr_pkg::entry_t'(rdata);
  assign sweep_done = (idx_q == DEPTH_C) && !chk_q;
  assign res_o      = res_q;
  assign less_sum   = {1'b0, less_q} + {{(17-CW){1'b0}}, npend_q};
  assign less_sat   = less_sum[16] ? rflr_pkg::CNT_MAX : less_sum[15:0];

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = rflr_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    valid_d    = valid_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    chk_d      = 1'b0;
    eidx_d     = eidx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_ent_d  = hit_ent_q;
    npend_d    = npend_q;
    remain_d   = remain_q;
    best_d     = best_q;
    best_key_d = best_key_q;
    best_idx_d = best_idx_q;
    more_d     = more_q;
    diff_d     = diff_q;
    less_d     = less_q;
    ovf_d      = ovf_q;
    res_d      = res_q;
    in_pop_o   = 1'b0;
    res_push_o = 1'b0;
    we         = 1'b0;
    waddr      = free_idx;

    // one table read per cycle while a sweep is running
    if ((state_q == S_SCAN || state_q == S_PEND || state_q == S_MIN) &&
        idx_q != DEPTH_C) begin
      idx_d  = idx_q + CW'(1);
      chk_d  = 1'b1;
      eidx_d = idx_q[IW-1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        in_pop_o = in_valid_i;
        if (in_valid_i) begin
          cur_d   = in_item_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          best_d  = 1'b0;
          npend_d = '0;
          pend_d  = '0;
          state_d = (in_item_i.cmd == rflr_pkg::CMD_DRAIN) ? S_PEND : S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_q && valid_q[eidx_q] && rent.key == cur_q.id) begin
          hit_d     = 1'b1;
          hit_idx_d = eidx_q;
          hit_ent_d = rent;
        end
        if (sweep_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        res_d   = '0;
        res_d.id = cur_q.id;
        if (cur_q.cmd == rflr_pkg::CMD_LOAD) begin
          if (!hit_q) begin
            if (free_any) begin
              we = 1'b1;
              valid_d[free_idx] = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end else if ((cur_q.status & mask_i) != 8'd0) begin
          if (hit_q) valid_d[hit_idx_q] = 1'b0;
        end else if (!hit_q) begin
          more_d = (more_q == rflr_pkg::CNT_MAX) ? more_q : more_q + 16'd1;
          res_d.category = rflr_pkg::CAT_MORE;
          state_d = S_EMIT;
        end else begin
          valid_d[hit_idx_q] = 1'b0;
          if (hit_ent_q.size != cur_q.size || hit_ent_q.crc != cur_q.crc) begin
            more_d = (more_q == rflr_pkg::CNT_MAX) ? more_q : more_q + 16'd1;
            res_d.category = rflr_pkg::CAT_MORE;
            state_d = S_EMIT;
          end else if (hit_ent_q.status != cur_q.status) begin
            diff_d = (diff_q == rflr_pkg::CNT_MAX) ? diff_q : diff_q + 16'd1;
            res_d.category = rflr_pkg::CAT_DIFF;
            state_d = S_EMIT;
          end
        end
      end
      S_PEND: begin
        if (chk_q && valid_q[eidx_q] && (rent.status & mask_i) == 8'd0) begin
          pend_d[eidx_q] = 1'b1;
          npend_d = npend_q + CW'(1);
        end
        if (sweep_done) begin
          less_d   = less_sat;
          remain_d = npend_q;
          if (npend_q == '0) begin
            res_d.category   = rflr_pkg::CAT_NONE;
            res_d.id         = '0;
            res_d.last       = 1'b1;
            res_d.overflow   = ovf_q;
            res_d.more_total = more_q;
            res_d.diff_total = diff_q;
            res_d.less_total = less_sat;
            state_d = S_EMIT;
          end else begin
            idx_d   = '0;
            best_d  = 1'b0;
            state_d = S_MIN;
          end
        end
      end
      S_MIN: begin
        if (chk_q && pend_q[eidx_q] && (!best_q || rent.key < best_key_q)) begin
          best_d     = 1'b1;
          best_key_d = rent.key;
          best_idx_d = eidx_q;
        end
        if (sweep_done) begin
          pend_d[best_idx_q] = 1'b0;
          remain_d = remain_q - CW'(1);
          res_d = '0;
          res_d.category = rflr_pkg::CAT_LESS;
          res_d.id       = best_key_q;
          if (remain_q == CW'(1)) begin
            res_d.last       = 1'b1;
            res_d.overflow   = ovf_q;
            res_d.more_total = more_q;
            res_d.diff_total = diff_q;
            res_d.less_total = less_q;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_push_o = !res_full_i;
        if (!res_full_i) begin
          if (res_q.last) begin
            valid_d = '0;
            more_d  = '0;
            diff_d  = '0;
            less_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else if (cur_q.cmd == rflr_pkg::CMD_DRAIN) begin
            idx_d   = '0;
            best_d  = 1'b0;
            state_d = S_MIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      pend_q   <= '0;
      idx_q    <= '0;
      chk_q    <= 1'b0;
      hit_q    <= 1'b0;
      npend_q  <= '0;
      remain_q <= '0;
      best_q   <= 1'b0;
      more_q   <= '0;
      diff_q   <= '0;
      less_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
      chk_q    <= chk_d;
      hit_q    <= hit_d;
      npend_q  <= npend_d;
      remain_q <= remain_d;
      best_q   <= best_d;
      more_q   <= more_d;
      diff_q   <= diff_d;
      less_q   <= less_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    eidx_q     <= eidx_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

endmodule
`default_nettype wire

/* rtl/replica_file_list_reconciler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// replica_file_list_reconciler_unit
// Compares a local file list against a 64-entry peer table keyed by file id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: push/full. Commands are load (peer entry), probe (local
//   entry) and drain. A two-deep input queue accepts transactions while the
//   engine works; unknown commands are accepted and dropped.
//   Result channel: empty/pop, fed from a two-deep result queue.
//   Each load or probe sweeps the table in RAM, one entry per cycle, once it
//   leaves the input queue: an idle step, the sweep and a decide step, plus
//   an emit step when it gives a result. A drain takes one sweep to mark
//   pending entries, then one sweep per "less" result for the minimum key,
//   plus an emit step per result to hand it to the result queue.
//   When the result queue is full the engine holds in place; the input queue
//   keeps taking transactions until it is full.
//   Reset empties the table and queues, clears counts and overflow, and sets
//   deleted_mask (APB offset 0) to 1. No clearing pass is needed.
//   Write deleted_mask only while the block is idle.
// ----------------------------------------------------------------------------
module replica_file_list_reconciler_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command_i,
  input  wire logic [63:0] file_id_i,
  input  wire logic [31:0] file_size_i,
  input  wire logic [31:0] file_crc_i,
  input  wire logic [7:0]  file_status_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       category_o,
  output logic [63:0]      out_file_id_o,
  output logic             last_o,
  output logic             overflow_o,
  output logic [15:0]      more_total_o,
  output logic [15:0]      diff_total_o,
  output logic [15:0]      less_total_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] mask_q;
  rflr_pkg::item_t in_item, q_item;
  rflr_pkg::res_t  eng_res, out_res;
  logic q_valid, q_pop, res_full, res_push;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, mask_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 8'd1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mask_q <= pwdata[7:0];
    end
  end

  assign in_item = '{cmd: command_i, id: file_id_i, size: file_size_i,
                     crc: file_crc_i, status: file_status_i};

  rflr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (in_item),
    .out_valid_o(q_valid),
    .out_item_o (q_item),
    .pop_i      (q_pop)
  );

  rflr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mask_i    (mask_q),
    .in_valid_i(q_valid),
    .in_item_i (q_item),
    .in_pop_o  (q_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (eng_res)
  );

  rflr_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (eng_res),
    .full_o (res_full),
    .empty_o(empty),
    .res_o  (out_res),
    .pop_i  (pop)
  );

  assign category_o    = out_res.category;
  assign out_file_id_o = out_res.id;
  assign last_o        = out_res.last;
  assign overflow_o    = out_res.overflow;
  assign more_total_o  = out_res.more_total;
  assign diff_total_o  = out_res.diff_total;
  assign less_total_o  = out_res.less_total;

endmodule
`default_nettype wire
